// ===== design/sqfd_pkg.sv =====
// Shared types and constants for the sparse quadratic form diagonal block.
package sqfd_pkg;
	localparam int NumAnnot     = 64;
	localparam int AnnotW       = $clog2(NumAnnot);
	localparam int MaxPerColumn = 64;
	localparam int GrpIdxW      = $clog2(MaxPerColumn);
	localparam int GrpCntW      = $clog2(MaxPerColumn + 1);
	localparam int ColW         = 20;
	localparam int ValW         = 16;
	localparam int SumW         = 64;
	localparam int CplDepth     = NumAnnot * NumAnnot;
	localparam int CplAddrW     = 2 * AnnotW;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_NONZERO = 2'd1,
		CMD_FLUSH = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	// Operation passed from the front end to the back end.
	typedef struct packed {
		logic               wr_cpl;
		logic               close;
		logic               push;
		logic [CplAddrW-1:0] cpl_addr;
		logic [AnnotW-1:0]  row;
		logic [ValW-1:0]    value;
		logic [ColW-1:0]    col;
		logic               dropped;
	} op_t;
endpackage

// ===== design/sparse_quadratic_form_diag_core.sv =====
// Top level of the sparse quadratic form diagonal block.
//
// Input channel (in_valid/in_ready) takes one command per beat: coupling
// writes, nonzeros of M grouped by column, and flushes. Output channel
// (out_valid/out_ready) gives one beat per closed column with its diagonal
// value of Mt C M, a saturation flag and a dropped-entries flag.
// A front end decodes commands and tracks the open column; a two-entry queue
// feeds the back end, which holds the coupling store and the group buffer.
// The back end takes coupling writes and nonzeros in its idle state. Closing a
// column of n nonzeros walks n*(n+1)/2 pairs through one shared
// multiply-accumulate; each pair takes a group read, a coupling read, two
// multiplies and an accumulate. Reset clears the group count, open column
// and flags; the coupling store holds no defined value until written. The
// result sits in an output register; while the receiver stalls, the back end
// keeps accepting writes and nonzeros and waits only when a second result
// would be due.
module sparse_quadratic_form_diag_core
	import sqfd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             command,
	input  logic [5:0]             annot_a,
	input  logic [5:0]             annot_b,
	input  logic [ColW-1:0]        column,
	input  logic signed [ValW-1:0] value,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [ColW-1:0]        out_column,
	output logic signed [SumW-1:0] diag_value,
	output logic                   saturated,
	output logic                   entries_dropped
);
	logic f_valid, f_ready, b_valid, b_ready;
	op_t  f_op, b_op;
	logic q_ready;

	sqfd_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.command(command), .annot_a(annot_a), .annot_b(annot_b),
		.column(column), .value(value),
		.op_valid(f_valid), .op_ready(f_ready), .op(f_op)
	);

	// Items that produce no operation are accepted whenever the queue has room.
	assign f_ready = q_ready;

	sqfd_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .in_valid(f_valid), .in_ready(q_ready),
		.in_op(f_op), .out_valid(b_valid), .out_ready(b_ready), .out_op(b_op)
	);

	sqfd_back u_back (
		.clk(clk), .arst_n(arst_n), .op_valid(b_valid), .op_ready(b_ready),
		.op(b_op), .out_valid(out_valid), .out_ready(out_ready),
		.out_column(out_column), .diag_value(diag_value), .saturated(saturated),
		.entries_dropped(entries_dropped)
	);
endmodule

// ===== design/sqfd_ram.sv =====
// Generic single-port-write, registered-read RAM.
module sqfd_ram #(
	parameter int Width = 16,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/sqfd_front.sv =====
// Front end: decodes commands, tracks the open column and group fill.
module sqfd_front
	import sqfd_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [1:0]      command,
	input  logic [5:0]      annot_a,
	input  logic [5:0]      annot_b,
	input  logic [ColW-1:0] column,
	input  logic [ValW-1:0] value,
	output logic            op_valid,
	input  logic            op_ready,
	output op_t             op
);
	logic [GrpCntW-1:0] count_q;
	logic [ColW-1:0]    col_q;
	logic               ovf_q;
	logic               close_now, push_now, full;
	logic               in_range;

	assign in_ready = op_ready;
	assign full = (count_q == GrpCntW'(MaxPerColumn));
	assign in_range = (32'(annot_a) < NumAnnot) && (32'(annot_b) < NumAnnot);

	always_comb begin
		close_now = 1'b0;
		push_now = 1'b0;
		op = '0;
		op.cpl_addr = {annot_a[AnnotW-1:0], annot_b[AnnotW-1:0]};
		op.row = annot_a[AnnotW-1:0];
		op.value = value;
		op.col = col_q;
		op.dropped = ovf_q;
		case (cmd_t'(command))
			CMD_WRITE: op.wr_cpl = in_range;
			CMD_NONZERO: begin
				close_now = (count_q != '0) && (column != col_q);
				push_now = close_now || !full;
			end
			CMD_FLUSH: close_now = (count_q != '0);
			default: ;
		endcase
		op.close = close_now;
		op.push = push_now;
	end

	// A nonzero whose row is outside the coupling store still occupies a slot.
	assign op_valid = in_valid && (op.wr_cpl || op.close || op.push);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			col_q <= '0;
			ovf_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			if (command == CMD_NONZERO) begin
				col_q <= column;
				if (close_now) begin
					count_q <= GrpCntW'(1);
					ovf_q <= 1'b0;
				end else if (full) begin
					ovf_q <= 1'b1;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end else if (close_now) begin
				count_q <= '0;
				ovf_q <= 1'b0;
			end
		end
	end
endmodule

// ===== design/sqfd_fifo.sv =====
// Two-entry queue between the front and back ends.
module sqfd_fifo
	import sqfd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  op_t  in_op,
	output logic out_valid,
	input  logic out_ready,
	output op_t  out_op
);
	op_t        slot_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign in_ready = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_op = slot_q[rd_q];
	assign wr = in_valid && in_ready;
	assign rd = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wr_q] <= in_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wr_q <= ~wr_q;
			if (rd) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end
endmodule

// ===== design/sqfd_back.sv =====
// Back end: coupling store, group buffer and the pairwise multiply-accumulate.
module sqfd_back
	import sqfd_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   op_valid,
	output logic                   op_ready,
	input  op_t                    op,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [ColW-1:0]        out_column,
	output logic signed [SumW-1:0] diag_value,
	output logic                   saturated,
	output logic                   entries_dropped
);
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_READ  = 5'b00010,
		ST_MUL1  = 5'b00100,
		ST_MUL2  = 5'b01000,
		ST_ACC   = 5'b10000
	} state_t;

	state_t              state_q;
	logic [GrpCntW-1:0]  count_q;
	logic [GrpIdxW-1:0]  k_q, l_q;
	logic signed [SumW-1:0] sum_q;
	logic                sat_q;
	logic [ColW-1:0]     col_q;
	logic                drop_q;
	logic                pend_push_q;
	op_t                 op_q;

	logic [AnnotW+ValW-1:0] grp_wdata, grp_k, grp_l;
	logic [GrpIdxW-1:0]  grp_waddr, grp_raddr_k, grp_raddr_l;
	logic                grp_we;
	logic [CplAddrW-1:0] cpl_addr;
	logic [ValW-1:0]     cpl_rdata;
	logic signed [31:0]  vv_q;
	logic signed [47:0]  prod_q;
	logic                diag_q;
	logic signed [SumW-1:0] term, nsum;
	logic                novf;
	logic                last_pair;
	logic                out_ready_ok;

	assign out_ready_ok = !out_valid || out_ready;

	// Group buffer is read at two addresses, so it is held twice.
	assign grp_we = (state_q == ST_IDLE) && op_valid && op.push && !op.close
		|| pend_push_q && state_q == ST_ACC && last_pair && out_ready_ok;

	always_comb begin
		if (pend_push_q) begin
			grp_wdata = {op_q.row, op_q.value};
			grp_waddr = '0;
		end else begin
			grp_wdata = {op.row, op.value};
			grp_waddr = count_q[GrpIdxW-1:0];
		end
	end

	assign grp_raddr_k = k_q;
	assign grp_raddr_l = l_q;

	sqfd_ram #(.Width(AnnotW + ValW), .Depth(MaxPerColumn)) u_grp_k (
		.clk(clk), .we(grp_we), .waddr(grp_waddr), .wdata(grp_wdata),
		.raddr(grp_raddr_k), .rdata(grp_k)
	);
	sqfd_ram #(.Width(AnnotW + ValW), .Depth(MaxPerColumn)) u_grp_l (
		.clk(clk), .we(grp_we), .waddr(grp_waddr), .wdata(grp_wdata),
		.raddr(grp_raddr_l), .rdata(grp_l)
	);

	// Outside the idle state, the coupling read address comes straight from the group buffer output.
	assign cpl_addr = (state_q == ST_IDLE) ? op.cpl_addr
		: {grp_k[AnnotW+ValW-1:ValW], grp_l[AnnotW+ValW-1:ValW]};

	sqfd_ram #(.Width(ValW), .Depth(CplDepth)) u_cpl (
		.clk(clk), .we((state_q == ST_IDLE) && op_valid && op.wr_cpl),
		.waddr(op.cpl_addr), .wdata(op.value), .raddr(cpl_addr), .rdata(cpl_rdata)
	);

	assign last_pair = (32'(l_q) + 1 >= 32'(count_q)) && (32'(k_q) + 1 >= 32'(count_q));

	// Truncate Q.36 to Q.24 by an arithmetic shift, then double off-diagonal terms.
	always_comb begin
		term = SumW'(prod_q >>> 12);
		if (!diag_q) term = term <<< 1;
		nsum = sum_q + term;
		novf = (sum_q[SumW-1] == term[SumW-1]) && (nsum[SumW-1] != sum_q[SumW-1]);
	end

	assign op_ready = (state_q == ST_IDLE) && !(op.close && out_valid && !out_ready);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_MUL1: begin
				vv_q <= 32'($signed(grp_k[ValW-1:0])) * 32'($signed(grp_l[ValW-1:0]));
				diag_q <= (k_q == l_q);
			end
			ST_MUL2: prod_q <= 48'($signed(cpl_rdata)) * 48'(vv_q);
			default: ;
		endcase
		if ((state_q == ST_IDLE) && op_valid && op_ready && op.close) begin
			op_q <= op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			k_q <= '0;
			l_q <= '0;
			sum_q <= '0;
			sat_q <= 1'b0;
			col_q <= '0;
			drop_q <= 1'b0;
			pend_push_q <= 1'b0;
			out_valid <= 1'b0;
			out_column <= '0;
			diag_value <= '0;
			saturated <= 1'b0;
			entries_dropped <= 1'b0;
		end else begin
			if (out_valid && out_ready && !(state_q == ST_ACC && last_pair)) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (op_valid && op_ready) begin
						if (op.close) begin
							state_q <= ST_READ;
							k_q <= '0;
							l_q <= '0;
							sum_q <= '0;
							sat_q <= 1'b0;
							col_q <= op.col;
							drop_q <= op.dropped;
							pend_push_q <= op.push;
						end else if (op.push) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				ST_READ: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_ACC;
				ST_ACC: begin
					if (!(last_pair && !out_ready_ok)) begin
						if (novf) begin
							sum_q <= sum_q[SumW-1] ? {1'b1, {(SumW-1){1'b0}}}
								: {1'b0, {(SumW-1){1'b1}}};
							sat_q <= 1'b1;
						end else begin
							sum_q <= nsum;
						end
						if (last_pair) begin
							out_valid <= 1'b1;
							out_column <= col_q;
							diag_value <= novf ? (sum_q[SumW-1] ? {1'b1, {(SumW-1){1'b0}}}
								: {1'b0, {(SumW-1){1'b1}}}) : nsum;
							saturated <= sat_q || novf;
							entries_dropped <= drop_q;
							count_q <= pend_push_q ? GrpCntW'(1) : '0;
							pend_push_q <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							if (32'(l_q) + 1 >= 32'(count_q)) begin
								k_q <= k_q + 1'b1;
								l_q <= k_q + 1'b1;
							end else begin
								l_q <= l_q + 1'b1;
							end
							state_q <= ST_READ;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== tb/sparse_quadratic_form_diag_core_test.sv =====
// Self-checking testbench for the sparse quadratic form diagonal block.
`timescale 1ns / 1ps

module sparse_quadratic_form_diag_core_test;
	import sqfd_pkg::*;

	localparam int  ItemTarget = 1850;
	localparam int  CycleLimit = 800000;
	localparam int  TailCycles = 300;

	typedef struct {
		logic [ColW-1:0]        col;
		logic signed [SumW-1:0] diag;
		logic                   sat;
		logic                   drop;
	} diag_result_t;

	typedef struct {
		cmd_t        cmd;
		int          a;
		int          b;
		int          col;
		int          val;
		bit          typed;
		int          exp_col;
		longint      exp_diag;
	} stim_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic [1:0]             command;
	logic [5:0]             annot_a;
	logic [5:0]             annot_b;
	logic [ColW-1:0]        column;
	logic signed [ValW-1:0] value;
	logic                   out_valid;
	logic                   out_ready;
	logic [ColW-1:0]        out_column;
	logic signed [SumW-1:0] diag_value;
	logic                   saturated;
	logic                   entries_dropped;

	sparse_quadratic_form_diag_core DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .annot_a(annot_a), .annot_b(annot_b),
		.column(column), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_column(out_column), .diag_value(diag_value),
		.saturated(saturated), .entries_dropped(entries_dropped)
	);

	// Mirror of the block state.
	logic signed [ValW-1:0] coupling [CplDepth];
	int                     grp_row [MaxPerColumn];
	logic signed [ValW-1:0] grp_val [MaxPerColumn];
	int                     grp_count;
	logic [ColW-1:0]        open_col;
	bit                     overflow;

	diag_result_t pending_diags [$];
	int           items_sent;
	int           mismatches;
	longint       cycles;
	bit           no_gap_mode;

	// Rows whose couplings with every other such row have been written.
	int ready_rows [$];
	bit is_ready_row [NumAnnot];

	int annot_b_shadow;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic diag_result_t close_column();
		diag_result_t r;
		logic signed [SumW:0] acc;
		longint prod;
		longint term;
		longint c;
		r.sat = 1'b0;
		acc = '0;
		for (int k = 0; k < grp_count; k++) begin
			for (int l = k; l < grp_count; l++) begin
				c = coupling[grp_row[k] * NumAnnot + grp_row[l]];
				prod = c * longint'(grp_val[k]) * longint'(grp_val[l]);
				term = prod >>> 12;
				if (k != l)
					term = term * 2;
				acc = acc + term;
				if (acc > 65'sh0_7FFF_FFFF_FFFF_FFFF) begin
					acc = 65'sh0_7FFF_FFFF_FFFF_FFFF;
					r.sat = 1'b1;
				end else if (acc < -65'sh0_8000_0000_0000_0000) begin
					acc = -65'sh0_8000_0000_0000_0000;
					r.sat = 1'b1;
				end
			end
		end
		r.col = open_col;
		r.diag = acc[SumW-1:0];
		r.drop = overflow;
		grp_count = 0;
		overflow = 1'b0;
		return r;
	endfunction

	// Advances the mirror by one accepted beat; returns 1 when a column closes.
	function automatic bit predict_beat(cmd_t c, int a, int col, int v,
			output diag_result_t r);
		bit got;
		got = 1'b0;
		case (c)
			CMD_WRITE: begin
				coupling[a * NumAnnot + annot_b_shadow] = v[ValW-1:0];
			end
			CMD_NONZERO: begin
				if (grp_count > 0 && col[ColW-1:0] != open_col) begin
					r = close_column();
					got = 1'b1;
				end
				open_col = col[ColW-1:0];
				if (grp_count < MaxPerColumn) begin
					grp_row[grp_count] = a;
					grp_val[grp_count] = v[ValW-1:0];
					grp_count++;
				end else begin
					overflow = 1'b1;
				end
			end
			CMD_FLUSH: begin
				if (grp_count > 0) begin
					r = close_column();
					got = 1'b1;
				end
			end
			default: ;
		endcase
		return got;
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (no_gap_mode || p < 65)
			return 0;
		if (p < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int pick_value();
		int p;
		p = $urandom_range(0, 99);
		if (p < 4)  return -32768;
		if (p < 8)  return 32767;
		if (p < 10) return 0;
		if (p < 12) return -1;
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	function automatic int pick_column();
		int p;
		p = $urandom_range(0, 99);
		if (p < 8)  return 0;
		if (p < 16) return (1 << ColW) - 1;
		if (p < 60) return $urandom_range(0, 15);
		return $urandom_range(0, (1 << ColW) - 1);
	endfunction

	task automatic send_beat(cmd_t c, int a, int b, int col, int v,
			bit typed, diag_result_t typed_res);
		int g;
		bit got;
		diag_result_t r;
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= c;
		annot_a <= a[5:0];
		annot_b <= b[5:0];
		column <= col[ColW-1:0];
		value <= v[ValW-1:0];
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
		annot_b_shadow = b & 6'h3F;
		got = predict_beat(c, a & 6'h3F, col, v, r);
		if (got) begin
			if (typed)
				pending_diags.push_back(typed_res);
			else
				pending_diags.push_back(r);
		end
	endtask

	task automatic send_plain(cmd_t c, int a, int b, int col, int v);
		diag_result_t unused;
		unused = '{default: '0};
		send_beat(c, a, b, col, v, 1'b0, unused);
	endtask

	task automatic add_ready_row(int r);
		for (int i = 0; i < ready_rows.size(); i++) begin
			send_plain(CMD_WRITE, r, ready_rows[i], pick_column(), pick_value());
			send_plain(CMD_WRITE, ready_rows[i], r, pick_column(), pick_value());
		end
		send_plain(CMD_WRITE, r, r, pick_column(), pick_value());
		ready_rows.push_back(r);
		is_ready_row[r] = 1'b1;
	endtask

	task automatic send_group(int n);
		int col;
		col = pick_column();
		for (int i = 0; i < n; i++)
			send_plain(CMD_NONZERO, ready_rows[$urandom_range(0, ready_rows.size() - 1)],
				$urandom_range(0, 63), col, pick_value());
		if ($urandom_range(0, 2) == 0)
			send_plain(CMD_FLUSH, $urandom_range(0, 63), $urandom_range(0, 63),
				pick_column(), pick_value());
	endtask

	// Output side: random backpressure and the comparison against the oldest expectation.
	initial begin : receiver
		int stall;
		diag_result_t e;
		stall = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_diags.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result beat: column %0d value %0d",
							out_column, diag_value);
				end else begin
					e = pending_diags.pop_front();
					if (out_column !== e.col || diag_value !== e.diag ||
							saturated !== e.sat || entries_dropped !== e.drop) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected col %0d val %0d sat %0b drop %0b, got col %0d val %0d sat %0b drop %0b",
								e.col, e.diag, e.sat, e.drop,
								out_column, diag_value, saturated, entries_dropped);
					end
				end
			end
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3: stall = $urandom_range(1, 3);
					4:          stall = $urandom_range(20, 60);
					default:    stall = 0;
				endcase
				out_ready <= (stall == 0);
			end
		end
	end

	stim_row_t directed [] = '{
		'{CMD_WRITE,   0,  0, 0,       -32768, 1'b0, 0, 0},
		'{CMD_WRITE,  63, 63, 1048575,  32767, 1'b0, 0, 0},
		'{CMD_WRITE,   0, 63, 0,         4096, 1'b0, 0, 0},
		'{CMD_WRITE,  63,  0, 0,         4096, 1'b0, 0, 0},
		// A flush with nothing buffered and the unused command give no beat.
		'{CMD_FLUSH,   0,  0, 0,            0, 1'b0, 0, 0},
		'{CMD_NONE,   63, 63, 1048575,     -1, 1'b0, 0, 0},
		'{CMD_NONZERO, 0, 63, 0,         4096, 1'b0, 0, 0},
		'{CMD_FLUSH,   0,  0, 0,            0, 1'b1, 0, -134217728},
		'{CMD_NONZERO,63,  0, 1048575, -32768, 1'b0, 0, 0},
		'{CMD_NONZERO, 0,  0, 1048575,   4096, 1'b0, 0, 0},
		// A new column closes the previous one.
		'{CMD_NONZERO,63, 63, 5,            1, 1'b1, 1048575, 64'sd8187019264},
		'{CMD_FLUSH,   0,  0, 0,            0, 1'b1, 5, 7},
		'{CMD_NONZERO, 0,  0, 7,           -1, 1'b0, 0, 0},
		'{CMD_FLUSH,   0,  0, 0,            0, 1'b1, 7, -8},
		'{CMD_NONZERO, 0,  0, 9,            1, 1'b0, 0, 0},
		'{CMD_NONZERO,63,  0, 9,           -1, 1'b0, 0, 0},
		'{CMD_FLUSH,   0,  0, 0,            0, 1'b1, 9, -3},
		// The same column again is reported again.
		'{CMD_NONZERO, 0,  0, 9,            1, 1'b0, 0, 0},
		'{CMD_FLUSH,   0,  0, 0,            0, 1'b1, 9, -8}
	};

	initial begin : stimulus
		diag_result_t t;
		bit long_done;
		int p;
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_NONE;
		annot_a = '0;
		annot_b = '0;
		column = '0;
		value = '0;
		cycles = 0;
		items_sent = 0;
		mismatches = 0;
		grp_count = 0;
		open_col = '0;
		overflow = 1'b0;
		no_gap_mode = 1'b0;
		long_done = 1'b0;
		for (int i = 0; i < CplDepth; i++)
			coupling[i] = '0;
		for (int i = 0; i < NumAnnot; i++)
			is_ready_row[i] = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			t.col = directed[i].exp_col[ColW-1:0];
			t.diag = directed[i].exp_diag;
			t.sat = 1'b0;
			t.drop = 1'b0;
			send_beat(directed[i].cmd, directed[i].a, directed[i].b, directed[i].col,
				directed[i].val, directed[i].typed, t);
		end
		ready_rows = '{0, 63};
		is_ready_row[0] = 1'b1;
		is_ready_row[63] = 1'b1;

		while (items_sent < ItemTarget) begin
			no_gap_mode = ($urandom_range(0, 4) == 0);
			p = $urandom_range(0, 99);
			if (!long_done && items_sent > ItemTarget / 2) begin
				// Let the output drain first, then overfill one column.
				if (pending_diags.size() != 0) begin
					in_valid <= 1'b0;
					while (pending_diags.size() != 0) @(posedge clk);
				end
				send_group(MaxPerColumn + $urandom_range(1, 4));
				long_done = 1'b1;
			end else if (p < 10 && ready_rows.size() < 14) begin
				p = $urandom_range(1, 62);
				while (is_ready_row[p]) p = $urandom_range(1, 62);
				add_ready_row(p);
			end else if (p < 18) begin
				send_plain(CMD_WRITE, ready_rows[$urandom_range(0, ready_rows.size() - 1)],
					ready_rows[$urandom_range(0, ready_rows.size() - 1)],
					pick_column(), pick_value());
			end else if (p < 23) begin
				send_plain($urandom_range(0, 1) ? CMD_NONE : CMD_FLUSH,
					$urandom_range(0, 63), $urandom_range(0, 63),
					pick_column(), pick_value());
			end else if (p < 24) begin
				send_group(MaxPerColumn + $urandom_range(0, 3));
			end else begin
				send_group($urandom_range(1, $urandom_range(0, 3) == 0 ? 12 : 5));
			end
		end
		send_plain(CMD_FLUSH, 0, 0, 0, 0);
		in_valid <= 1'b0;

		while (pending_diags.size() != 0) @(posedge clk);
		repeat (TailCycles) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ===== files.f =====
design/sqfd_pkg.sv
design/sqfd_ram.sv
design/sqfd_front.sv
design/sqfd_fifo.sv
design/sqfd_back.sv
design/sparse_quadratic_form_diag_core.sv
tb/sparse_quadratic_form_diag_core_test.sv
